// ----- hw/rtl/des_pkg.sv -----
// Package for the DES block cipher: permutation and S-box tables and the
// functions built on them (key schedule, Feistel round). No dependencies.
`default_nettype none
package des_pkg;

  localparam int unsigned NumRounds = 16;
  localparam int unsigned HalfKeyW  = 28;
  localparam int unsigned HalfBlkW  = 32;
  localparam int unsigned LastRound = 15;

  typedef logic [47:0] rkey_t;
  typedef rkey_t rkeys_t [NumRounds];

  localparam logic [6:0] IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [6:0] FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [5:0] E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [5:0] P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam logic [6:0] PC1_TAB [56] = '{
    57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
    10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

  localparam logic [5:0] PC2_TAB [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam logic [1:0] ROT_TAB [NumRounds] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] SBOX_TAB [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Tables count bits from the MSB, starting at 1.
  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = x[64-IP_TAB[k]];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = x[64-FP_TAB[k]];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] rh, input rkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int k2 = 0; k2 < 48; k2++) x[47-k2] = rh[32-E_TAB[k2]];
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SBOX_TAB[b][{six[5], six[0], six[4:1]}];
    end
    for (int k2 = 0; k2 < 32; k2++) p[31-k2] = s[32-P_TAB[k2]];
    return p;
  endfunction

  // One round, always swapping; the caller undoes the final swap.
  function automatic logic [63:0] des_round(input logic [63:0] lr, input rkey_t k);
    return {lr[31:0], lr[63:32] ^ feistel(lr[31:0], k)};
  endfunction

  function automatic rkeys_t key_schedule(input logic [63:0] key);
    rkeys_t rk;
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] cdr;
    for (int k = 0; k < 56; k++) cd[55-k] = key[64-PC1_TAB[k]];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < NumRounds; i++) begin
      if (ROT_TAB[i] == 2'd2) begin
        c = {c[25:0], c[27:26]};
        d = {d[25:0], d[27:26]};
      end else begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cdr = {c, d};
      for (int k = 0; k < 48; k++) rk[i][47-k] = cdr[56-PC2_TAB[k]];
    end
    return rk;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/des_block_cipher_top.sv -----
// Single-DES block cipher engine, one 64-bit block per beat.
// Depends on des_pkg for tables, key schedule and the round function.
//
//  channel  dir  handshake                fields
//  in_      in   in_tvalid / in_tready    tdata[63:0] data_block
//  out_     out  out_tvalid / out_tready  tdata[63:0] result_block
//  cfg_     in   APB psel/penable/pready  0x0 cipher_key, 0x8 decrypt_mode
//
// Three register stages: input register, eight rounds to a middle register,
// eight rounds plus the final permutation to the output register. A block
// passes the three registers in order; one block per cycle while out_tready
// stays high. Round keys are plain wiring from the key register. Reset
// empties the pipeline and clears both registers; a stalled output holds a
// stage only when every stage after it is full.
`default_nettype none
module des_block_cipher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] data_block
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] result_block
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import des_pkg::*;

  localparam logic RegKey  = 1'b0;
  localparam logic RegMode = 1'b1;

  logic [63:0] key_r;
  logic        mode_r;
  logic        v0_r, v1_r, vo_r;
  logic [63:0] d0_r, d1_r, do_r;
  logic        adv0, adv1, adv2;
  logic        cfg_wr;
  rkeys_t      rk;
  rkey_t       ksel [NumRounds];
  logic [63:0] d1_nxt, do_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        RegKey:  key_r  <= cfg_pwdata;
        RegMode: mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3])
      RegKey:  cfg_prdata = key_r;
      RegMode: cfg_prdata = {63'd0, mode_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign rk = key_schedule(key_r);
  always_comb begin
    for (int i = 0; i < NumRounds; i++) ksel[i] = mode_r ? rk[LastRound-i] : rk[i];
  end

  always_comb begin
    d1_nxt = perm_ip(d0_r);
    for (int i = 0; i < NumRounds/2; i++) d1_nxt = des_round(d1_nxt, ksel[i]);
    do_nxt = d1_r;
    for (int i = NumRounds/2; i < NumRounds; i++) do_nxt = des_round(do_nxt, ksel[i]);
    do_nxt = perm_fp({do_nxt[31:0], do_nxt[63:32]});
  end

  assign adv2 = !vo_r || out_tready;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;
  assign in_tready = adv0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (adv0) v0_r <= in_tvalid;
      if (adv1) v1_r <= v0_r;
      if (adv2) vo_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) d0_r <= in_tdata;
    if (adv1) d1_r <= d1_nxt;
    if (adv2) do_r <= do_nxt;
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = do_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v0_r)
    else $error("accepted beat did not reach the input stage");
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !adv1 |=> v1_r && $stable(d1_r))
    else $error("middle stage changed while stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

endmodule
`default_nettype wire
